FILE: hw/rtl/piecewise_linear_table_interp_unit_macros.svh
// Assertion macros for the piecewise linear table interpolation unit.
// Included by the top level; needs nothing else.
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_UNIT_MACROS_SVH

// same-cycle implication, reset masked
`define PLTI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define PLTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/plti_pkg.sv
// Shared types, constants and helpers for the interpolation unit.
// Used by plti_dp, plti_ctrl and piecewise_linear_table_interp_unit.
package plti_pkg;

  localparam int TABLE_ROWS  = 64;
  localparam int VALUE_WIDTH = 24;
  localparam int ROW_W       = $clog2(TABLE_ROWS);
  localparam int ROWS_W      = 7;
  localparam int LAM_W       = 16;
  localparam int PROD_W      = VALUE_WIDTH + 1 + LAM_W + 1;
  localparam int SUM_W       = VALUE_WIDTH + 3;
  localparam int CNT_W       = 4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [ROWS_W-1:0] ROWS_MIN = ROWS_W'(2);
  localparam logic [ROWS_W-1:0] ROWS_MAX = ROWS_W'(TABLE_ROWS);

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(LAM_W - 1);

  // coefficient select; COEF_NONE only drains the blend pipeline
  localparam logic [1:0] COEF_LIFT   = 2'd0;
  localparam logic [1:0] COEF_DRAG   = 2'd1;
  localparam logic [1:0] COEF_MOMENT = 2'd2;
  localparam logic [1:0] COEF_NONE   = 2'd3;

  typedef struct packed {
    logic                          operation;
    logic [ROW_W-1:0]              row_index;
    logic signed [VALUE_WIDTH-1:0] angle;
    logic signed [VALUE_WIDTH-1:0] lift_in;
    logic signed [VALUE_WIDTH-1:0] drag_in;
    logic signed [VALUE_WIDTH-1:0] moment_in;
  } plti_in_t;

  typedef struct packed {
    logic                          in_range;
    logic signed [VALUE_WIDTH-1:0] lift_out;
    logic signed [VALUE_WIDTH-1:0] drag_out;
    logic signed [VALUE_WIDTH-1:0] moment_out;
  } plti_out_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] bp;
    logic signed [VALUE_WIDTH-1:0] lift;
    logic signed [VALUE_WIDTH-1:0] drag;
    logic signed [VALUE_WIDTH-1:0] moment;
  } plti_row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEARCH,
    ST_DIVIDE,
    ST_BLEND,
    ST_OUT
  } plti_state_t;

  typedef struct packed {
    logic       mem_we;
    logic       query_init;
    logic       fetch;
    logic       div_init;
    logic       div_step;
    logic       blend_step;
    logic [1:0] blend_idx;
    logic       res_first;
    logic       res_miss;
  } plti_cmd_t;

  typedef struct packed {
    logic found;     // query angle <= breakpoint of current row
    logic first;     // current row is row 0
    logic eq_first;  // query angle == breakpoint of current row
    logic at_last;   // current row is the last one in use
  } plti_sts_t;

  function automatic logic signed [VALUE_WIDTH-1:0] coef_of(input plti_row_t r,
                                                            input logic [1:0] sel);
    logic signed [VALUE_WIDTH-1:0] v;
    unique case (sel)
      COEF_LIFT:   v = r.lift;
      COEF_DRAG:   v = r.drag;
      COEF_MOMENT: v = r.moment;
      default:     v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] sat_value(
      input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [VALUE_WIDTH-1:0] r;
    hi = SUM_W'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      r = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end else if (v < lo) begin
      r = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      r = v[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/plti_dp.sv
// Datapath: row memory, search compare, serial divider, shared blend multiplier.
// Depends on plti_pkg; driven by plti_ctrl commands.
module plti_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [plti_pkg::ROWS_W-1:0]        cfg_wdata,
  input  plti_pkg::plti_in_t                 in_data,
  input  plti_pkg::plti_cmd_t                cmd,
  output plti_pkg::plti_sts_t                sts,
  output plti_pkg::plti_out_t                out_data
);
  import plti_pkg::*;

  plti_row_t mem [TABLE_ROWS];

  logic [ROWS_W-1:0]             rows_r;
  logic [ROWS_W-1:0]             n_eff;
  logic [ROW_W-1:0]              last_idx;
  logic [ROW_W-1:0]              rd_idx_r;
  logic [ROW_W-1:0]              cmp_idx_r;
  plti_row_t                     rd_data_r;
  plti_row_t                     prev_r;
  logic signed [VALUE_WIDTH-1:0] x_r;

  logic [VALUE_WIDTH-1:0]        rem_r;
  logic [VALUE_WIDTH-1:0]        den_r;
  logic [LAM_W-1:0]              q_r;
  logic [VALUE_WIDTH:0]          num_diff;
  logic [VALUE_WIDTH:0]          den_diff;
  logic [VALUE_WIDTH:0]          rem_sh;

  logic signed [VALUE_WIDTH-1:0] coef_a;
  logic signed [VALUE_WIDTH-1:0] coef_b;
  logic signed [VALUE_WIDTH:0]   diff;
  logic signed [LAM_W:0]         lam_s;
  logic signed [PROD_W-1:0]      mul_r;
  logic signed [PROD_W-1:0]      rnd_full;
  logic signed [PROD_W-LAM_W-1:0] rnd;
  logic [1:0]                    acc_sel;
  logic signed [VALUE_WIDTH-1:0] acc_b;
  logic signed [SUM_W-1:0]       acc_sum;
  logic signed [VALUE_WIDTH-1:0] acc_val;
  plti_out_t                     res_r;

  // row count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_MIN;
    end else if (cfg_we) begin
      rows_r <= cfg_wdata;
    end
  end

  always_comb begin
    priority if (rows_r < ROWS_MIN) begin
      n_eff = ROWS_MIN;
    end else if (rows_r > ROWS_MAX) begin
      n_eff = ROWS_MAX;
    end else begin
      n_eff = rows_r;
    end
    last_idx = ROW_W'(n_eff - ROWS_W'(1));
  end

  // row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[in_data.row_index] <= '{bp:     in_data.angle,
                                  lift:   in_data.lift_in,
                                  drag:   in_data.drag_in,
                                  moment: in_data.moment_in};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // search walk; previous row is kept as the lower neighbor
  always_ff @(posedge clk) begin
    if (cmd.query_init) begin
      x_r      <= in_data.angle;
      rd_idx_r <= '0;
    end else if (cmd.fetch) begin
      prev_r    <= rd_data_r;
      cmp_idx_r <= rd_idx_r;
      rd_idx_r  <= rd_idx_r + ROW_W'(1);
    end
  end

  assign sts.found    = (x_r <= rd_data_r.bp);
  assign sts.eq_first = (x_r == rd_data_r.bp);
  assign sts.first    = (cmp_idx_r == '0);
  assign sts.at_last  = (cmp_idx_r == last_idx);

  // restoring divider, one quotient bit per step; remainder stays below divisor
  assign num_diff = {rd_data_r.bp[VALUE_WIDTH-1], rd_data_r.bp} - {x_r[VALUE_WIDTH-1], x_r};
  assign den_diff = {rd_data_r.bp[VALUE_WIDTH-1], rd_data_r.bp}
                  - {prev_r.bp[VALUE_WIDTH-1], prev_r.bp};
  assign rem_sh   = {rem_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= num_diff[VALUE_WIDTH-1:0];
      den_r <= den_diff[VALUE_WIDTH-1:0];
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= VALUE_WIDTH'(rem_sh - {1'b0, den_r});
        q_r   <= {q_r[LAM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[VALUE_WIDTH-1:0];
        q_r   <= {q_r[LAM_W-2:0], 1'b0};
      end
    end
  end

  // blend: multiply coefficient k while rounding/saturating coefficient k-1
  assign coef_a = coef_of(prev_r, cmd.blend_idx);
  assign coef_b = coef_of(rd_data_r, cmd.blend_idx);
  assign diff   = {coef_a[VALUE_WIDTH-1], coef_a} - {coef_b[VALUE_WIDTH-1], coef_b};
  assign lam_s  = {1'b0, q_r};

  always_ff @(posedge clk) begin
    if (cmd.blend_step && cmd.blend_idx != COEF_NONE) begin
      mul_r <= diff * lam_s;
    end
  end

  assign acc_sel  = cmd.blend_idx - 2'd1;
  assign acc_b    = coef_of(rd_data_r, acc_sel);
  assign rnd_full = mul_r + PROD_W'(signed'(1 << (LAM_W - 1)));
  assign rnd      = rnd_full[PROD_W-1:LAM_W];
  assign acc_sum  = {{3{acc_b[VALUE_WIDTH-1]}}, acc_b} + {rnd[PROD_W-LAM_W-1], rnd};
  assign acc_val  = sat_value(acc_sum);

  always_ff @(posedge clk) begin
    if (cmd.res_miss) begin
      res_r <= '0;
    end else if (cmd.res_first) begin
      res_r.in_range   <= sts.eq_first;
      res_r.lift_out   <= sts.eq_first ? rd_data_r.lift   : '0;
      res_r.drag_out   <= sts.eq_first ? rd_data_r.drag   : '0;
      res_r.moment_out <= sts.eq_first ? rd_data_r.moment : '0;
    end else if (cmd.div_init) begin
      res_r.in_range <= 1'b1;
    end else if (cmd.blend_step && cmd.blend_idx != COEF_LIFT) begin
      unique case (acc_sel)
        COEF_LIFT:   res_r.lift_out   <= acc_val;
        COEF_DRAG:   res_r.drag_out   <= acc_val;
        default:     res_r.moment_out <= acc_val;
      endcase
    end
  end

  assign out_data = res_r;

endmodule

FILE: hw/rtl/plti_ctrl.sv
// Controller FSM: sequences search, divide, blend and the result strobe.
// Depends on plti_pkg; drives plti_dp through a command struct.
module plti_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 operation,
  input  plti_pkg::plti_sts_t  sts,
  output plti_pkg::plti_cmd_t  cmd,
  output logic                 busy,
  output logic                 out_valid
);
  import plti_pkg::*;

  plti_state_t      state_r;
  plti_state_t      state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.blend_idx = cnt_r[1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_LOAD) begin
            cmd.mem_we = 1'b1;
          end else begin
            cmd.query_init = 1'b1;
            state_nxt      = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        priority if (sts.found) begin
          if (sts.first) begin
            cmd.res_first = 1'b1;
            state_nxt     = ST_OUT;
          end else begin
            cmd.div_init = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = ST_DIVIDE;
          end
        end else if (sts.at_last) begin
          cmd.res_miss = 1'b1;
          state_nxt    = ST_OUT;
        end else begin
          cmd.fetch = 1'b1;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_BLEND;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_BLEND: begin
        cmd.blend_step = 1'b1;
        if (cnt_r[1:0] == COEF_NONE) begin
          cnt_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

endmodule

FILE: hw/rtl/piecewise_linear_table_interp_unit.sv
// Top level of the piecewise linear table interpolation unit.
// Depends on plti_pkg, plti_ctrl, plti_dp and the assertion macro header.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------
//   input    | start / busy       | in_data  (plti_in_t)
//   result   | out_valid strobe   | out_data (plti_out_t)
//   config   | cfg_we             | cfg_wdata (rows_in_use)
//
// A load transaction writes one row in the accept cycle; busy stays low.
// A query searches one row per cycle over the single memory read port, then runs
// the 16-step divider and the 4-step blend before the result strobe; a row-0 hit
// or a miss skips divide and blend.
// Synchronous active-low reset; the table is undefined until loaded.
// The receiver cannot stall: out_valid is high for one cycle per query.
module piecewise_linear_table_interp_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  plti_pkg::plti_in_t             in_data,
  output logic                           out_valid,
  output plti_pkg::plti_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [plti_pkg::ROWS_W-1:0]    cfg_wdata
);
  import plti_pkg::*;

  `include "piecewise_linear_table_interp_unit_macros.svh"

  plti_cmd_t cmd;
  plti_sts_t sts;

  plti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_data.operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  plti_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  `PLTI_ASSERT_NOW(a_strobe_busy, clk, rst_n, out_valid, busy, "result strobe while idle")
  `PLTI_ASSERT_NEXT(a_query_busy, clk, rst_n,
    start && !busy && (in_data.operation == OP_QUERY), busy, "query accepted but not busy")
  `PLTI_ASSERT_NEXT(a_one_strobe, clk, rst_n, out_valid, !out_valid && !busy,
    "result strobe longer than one cycle")
  `PLTI_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_data.in_range,
    (out_data.lift_out == '0) && (out_data.drag_out == '0) && (out_data.moment_out == '0),
    "out-of-range result not zero")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for piecewise_linear_table_interp_unit.
// Depends on plti_pkg and the unit: it loads lookup tables, queries them and
// checks every result against an in-bench interpolation predictor.
module testbench;
  import plti_pkg::*;

  localparam longint VMIN          = -(longint'(1) << (VALUE_WIDTH - 1));
  localparam longint VMAX          = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
  localparam int     ITEM_GOAL     = 1100;
  localparam int     SETTLE_CYCLES = 100;
  localparam int     CYCLE_LIMIT   = 1000000;
  localparam int     MAX_PRINTS    = 40;

  class interp_scoreboard;
    logic signed [VALUE_WIDTH-1:0] bp_tab[TABLE_ROWS];
    logic signed [VALUE_WIDTH-1:0] lift_tab[TABLE_ROWS];
    logic signed [VALUE_WIDTH-1:0] drag_tab[TABLE_ROWS];
    logic signed [VALUE_WIDTH-1:0] moment_tab[TABLE_ROWS];
    logic [ROWS_W-1:0]             rows_cfg;
    plti_out_t                     expected_q[$];
    int                            fails;
    int                            checked;

    function new();
      rows_cfg = ROWS_MIN;
      fails    = 0;
      checked  = 0;
    endfunction

    function int active_rows();
      if (rows_cfg < ROWS_MIN) return int'(ROWS_MIN);
      if (rows_cfg > ROWS_MAX) return int'(ROWS_MAX);
      return int'(rows_cfg);
    endfunction

    function void set_rows(logic [ROWS_W-1:0] v);
      rows_cfg = v;
    endfunction

    // restoring division, 16 quotient bits
    function logic [LAM_W-1:0] div_weight(longint num, longint den);
      logic [63:0] rem;
      logic [63:0] q;
      rem = num;
      q   = '0;
      for (int k = 0; k < LAM_W; k++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= den) begin
          rem  = rem - den;
          q[0] = 1'b1;
        end
      end
      return q[LAM_W-1:0];
    endfunction

    // b + round((a - b) * lam / 2^16), ties upward, then saturate
    function logic signed [VALUE_WIDTH-1:0] mix_coef(longint a, longint b,
                                                     logic [LAM_W-1:0] lam);
      longint s;
      s = b + (((a - b) * longint'(lam) + 32768) >>> LAM_W);
      if (s > VMAX) s = VMAX;
      else if (s < VMIN) s = VMIN;
      return VALUE_WIDTH'(s);
    endfunction

    function plti_out_t interp_at(logic signed [VALUE_WIDTH-1:0] x);
      plti_out_t        r;
      int               n;
      int               i;
      logic [LAM_W-1:0] lam;
      r = '0;
      n = active_rows();
      i = 0;
      while (i < n && x > bp_tab[i]) i++;
      if (i == 0) begin
        if (x == bp_tab[0]) begin
          r.in_range   = 1'b1;
          r.lift_out   = lift_tab[0];
          r.drag_out   = drag_tab[0];
          r.moment_out = moment_tab[0];
        end
      end else if (i < n) begin
        lam = div_weight(longint'(bp_tab[i]) - longint'(x),
                         longint'(bp_tab[i]) - longint'(bp_tab[i-1]));
        r.in_range   = 1'b1;
        r.lift_out   = mix_coef(lift_tab[i-1], lift_tab[i], lam);
        r.drag_out   = mix_coef(drag_tab[i-1], drag_tab[i], lam);
        r.moment_out = mix_coef(moment_tab[i-1], moment_tab[i], lam);
      end
      return r;
    endfunction

    function void note(plti_in_t t);
      if (t.operation == OP_LOAD) begin
        bp_tab[t.row_index]     = t.angle;
        lift_tab[t.row_index]   = t.lift_in;
        drag_tab[t.row_index]   = t.drag_in;
        moment_tab[t.row_index] = t.moment_in;
      end else begin
        expected_q = {expected_q, interp_at(t.angle)};
      end
    endfunction

    task report_mismatch(string msg);
      fails++;
      if (fails <= MAX_PRINTS) $display("mismatch at result %0d: %s", checked, msg);
    endtask

    task check(plti_out_t r);
      plti_out_t w;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no query outstanding");
      end else begin
        w = expected_q.pop_front();
        if (r.in_range !== w.in_range)
          report_mismatch($sformatf("in_range got %0d want %0d", r.in_range, w.in_range));
        if (r.lift_out !== w.lift_out)
          report_mismatch($sformatf("lift_out got %0d want %0d", r.lift_out, w.lift_out));
        if (r.drag_out !== w.drag_out)
          report_mismatch($sformatf("drag_out got %0d want %0d", r.drag_out, w.drag_out));
        if (r.moment_out !== w.moment_out)
          report_mismatch($sformatf("moment_out got %0d want %0d",
                                    r.moment_out, w.moment_out));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  plti_in_t          in_data;
  logic              out_valid;
  plti_out_t         out_data;
  logic              cfg_we;
  logic [ROWS_W-1:0] cfg_wdata;

  interp_scoreboard sb;
  bit               burst;
  int               sent;
  int               cycles = 0;
  int               phase;

  piecewise_linear_table_interp_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // results cannot be held off: take each strobe as it comes
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_data);
  end

  function automatic longint pick_between(longint a, longint b);
    return a + longint'($urandom) % (b - a + 1);
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0:       return VALUE_WIDTH'(VMIN);
      1:       return VALUE_WIDTH'(VMAX);
      2:       return '0;
      3:       return '1;
      default: return VALUE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic plti_in_t row_item(int row, longint bp, longint l, longint d,
                                        longint m);
    plti_in_t t;
    t.operation = OP_LOAD;
    t.row_index = ROW_W'(row);
    t.angle     = VALUE_WIDTH'(bp);
    t.lift_in   = VALUE_WIDTH'(l);
    t.drag_in   = VALUE_WIDTH'(d);
    t.moment_in = VALUE_WIDTH'(m);
    return t;
  endfunction

  function automatic plti_in_t load_item(int row, longint bp);
    return row_item(row, bp, rand_coef(), rand_coef(), rand_coef());
  endfunction

  // row and coefficient fields are don't-care on a query; keep them random
  function automatic plti_in_t query_item(longint x);
    plti_in_t t;
    t.operation = OP_QUERY;
    t.row_index = ROW_W'($urandom);
    t.angle     = VALUE_WIDTH'(x);
    t.lift_in   = VALUE_WIDTH'($urandom);
    t.drag_in   = VALUE_WIDTH'($urandom);
    t.moment_in = VALUE_WIDTH'($urandom);
    return t;
  endfunction

  function automatic longint query_angle(int n);
    longint lo;
    longint hi;
    longint first;
    longint last;
    longint x;
    int     j;
    int     sel;
    sel   = $urandom_range(0, 99);
    j     = $urandom_range(1, n - 1);
    lo    = sb.bp_tab[j-1];
    hi    = sb.bp_tab[j];
    first = sb.bp_tab[0];
    last  = sb.bp_tab[n-1];
    x     = pick_between(VMIN, VMAX);
    if (sel < 55) begin
      if (lo < hi) begin
        case ($urandom_range(0, 7))
          0:       x = lo + 1;
          1:       x = hi;
          default: x = pick_between(lo + 1, hi);
        endcase
      end
    end else if (sel < 70) begin
      x = sb.bp_tab[$urandom_range(0, n - 1)];
    end else if (sel < 78) begin
      if (first > VMIN) x = $urandom_range(0, 1) ? first - 1 : pick_between(VMIN, first - 1);
    end else if (sel < 86) begin
      if (last < VMAX) x = $urandom_range(0, 1) ? last + 1 : pick_between(last + 1, VMAX);
    end else if (sel < 92) begin
      x = $urandom_range(0, 1) ? hi - 1 : hi + 1;
      if (x < VMIN) x = VMIN;
      if (x > VMAX) x = VMAX;
    end
    return x;
  endfunction

  task automatic send(plti_in_t t);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (busy);
    sb.note(t);
    sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_rows(logic [ROWS_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_rows(v);
  endtask

  task automatic run_phase(int phase_no);
    int                n;
    int                mode;
    int                nq;
    int                j;
    int                k;
    int                tmp;
    int                pick;
    int                order[TABLE_ROWS];
    longint            base;
    longint            smax;
    longint            bps[TABLE_ROWS];
    logic [ROWS_W-1:0] v;
    pick = $urandom_range(0, 9);
    if (phase_no < 2 || pick == 9) n = TABLE_ROWS;
    else if (pick >= 7) n = $urandom_range(7, 16);
    else n = $urandom_range(2, 6);
    // register values past the table size or below two are clamped by the unit
    if (phase_no == 0) v = '1;
    else if (phase_no == 1) v = ROWS_MAX;
    else if (n == TABLE_ROWS) v = ROWS_W'($urandom_range(TABLE_ROWS, 127));
    else if (n == 2) v = ROWS_W'($urandom_range(0, 2));
    else v = ROWS_W'(n);
    write_rows(v);
    burst = ($urandom_range(0, 3) == 0);

    mode = $urandom_range(0, 3);
    case (mode)
      0: begin
        smax = 16;
        base = pick_between(VMIN, VMAX - 16 * (n - 1));
      end
      1: begin
        base = pick_between(VMIN, VMAX - (n - 1));
        smax = (VMAX - base) / (n - 1);
      end
      default: begin
        base = VMIN;
        smax = (VMAX - VMIN) / (n - 1);
      end
    endcase
    bps[0] = base;
    for (k = 1; k < n; k++) bps[k] = bps[k-1] + pick_between(1, smax);
    if (mode == 2) bps[n-1] = VMAX;
    // unordered breakpoints: the search still runs, pairs just get odd
    if (mode == 3) for (k = 0; k < n; k++) bps[k] = pick_between(VMIN, VMAX);

    for (k = 0; k < n; k++) order[k] = k;
    for (k = n - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < n; k++) send(load_item(order[k], bps[order[k]]));

    nq = $urandom_range(20, 50);
    repeat (nq) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        wait_drained();
      end else if (pick < 15) begin
        tmp = $urandom_range(0, 3);
        if (tmp < 2) begin
          j = $urandom_range(0, n - 1);
          send(load_item(j, sb.bp_tab[j]));
        end else if (tmp == 2) begin
          send(load_item($urandom_range(0, TABLE_ROWS - 1), pick_between(VMIN, VMAX)));
        end else if (n < TABLE_ROWS) begin
          send(load_item($urandom_range(n, TABLE_ROWS - 1), pick_between(VMIN, VMAX)));
        end
      end
      send(query_item(query_angle(n)));
    end
  endtask

  initial begin
    sb        = new();
    burst     = 1'b0;
    sent      = 0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // two-row table spanning the full angle range
    send(row_item(0, VMIN, VMAX, VMIN, 0));
    send(row_item(1, VMAX, VMIN, VMAX, -1));
    send(query_item(VMIN));
    send(query_item(VMAX));
    send(query_item(VMIN + 1));
    send(query_item(0));
    send(query_item(-1));
    // above the last breakpoint, on it, below and on the first one
    send(row_item(1, 100, VMIN, VMAX, VMAX));
    send(query_item(101));
    send(query_item(100));
    send(row_item(0, 50, VMAX, VMIN, VMIN));
    send(query_item(49));
    send(query_item(50));
    send(query_item(51));
    // breakpoints out of order
    send(row_item(0, 200, 1, 2, 3));
    send(query_item(150));
    send(query_item(250));
    send(row_item(0, -5, 7, -7, 1));
    write_rows('0);
    send(query_item(40));
    write_rows(ROWS_W'(1));
    send(query_item(-5));

    phase = 0;
    while (sent < ITEM_GOAL) begin
      run_phase(phase);
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/plti_pkg.sv
hw/rtl/plti_dp.sv
hw/rtl/plti_ctrl.sv
hw/rtl/piecewise_linear_table_interp_unit.sv
tb/sv/testbench.sv
